>>> rtl/core/ps2mct_pkg.sv
// Shared types, constants and helper functions for the PS/2 mouse cursor tracker.
// No dependencies; imported by every module of the block.
package ps2mct_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_ENABLE  = 3'd0;
	localparam logic [2:0] CFG_COL_MAX = 3'd1;
	localparam logic [2:0] CFG_ROW_MAX = 3'd2;
	localparam logic [2:0] CFG_X_THR   = 3'd3;
	localparam logic [2:0] CFG_Y_THR   = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 7;

	// Configuration reset values
	localparam logic [6:0] COL_MAX_RST = 7'd79;
	localparam logic [4:0] ROW_MAX_RST = 5'd24;
	localparam logic [5:0] X_THR_RST   = 6'd6;
	localparam logic [4:0] Y_THR_RST   = 5'd8;

	// Delta clamp limits and the reciprocal used for the divide by six
	localparam logic signed [7:0] X_CLAMP = 8'sd80;
	localparam logic signed [7:0] Y_CLAMP = 8'sd64;
	localparam logic [5:0]        DIV6_RECIP = 6'd43; // round(256 / 6), exact for 0..64

	// Header byte bits
	localparam int HDR_X_OVF = 6;
	localparam int HDR_Y_OVF = 7;

	// Glyph codes
	localparam logic [1:0] GLYPH_PLUS   = 2'd0;
	localparam logic [1:0] GLYPH_LEFT   = 2'd1;
	localparam logic [1:0] GLYPH_RIGHT  = 2'd2;
	localparam logic [1:0] GLYPH_MIDDLE = 2'd3;

	// Button bits
	localparam int BTN_LEFT   = 0;
	localparam int BTN_RIGHT  = 1;
	localparam int BTN_MIDDLE = 2;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_X      = 2'd1,
		PH_Y      = 2'd2
	} frame_phase_t;

	// Framer result for one byte: button and delta state after the byte, plus flags
	typedef struct packed {
		logic [2:0]        buttons;
		logic signed [7:0] x_delta;
		logic signed [7:0] y_delta;
		logic              button_event;
		logic              packet_done;
		logic              overflow_drop;
	} pkt_info_t;

	function automatic logic [1:0] glyph_of(input logic [2:0] btn);
		logic [1:0] g;
		if (btn[BTN_LEFT])
			g = GLYPH_LEFT;
		else if (btn[BTN_RIGHT])
			g = GLYPH_RIGHT;
		else if (btn[BTN_MIDDLE])
			g = GLYPH_MIDDLE;
		else
			g = GLYPH_PLUS;
		return g;
	endfunction

endpackage

>>> rtl/core/ps2mct_framer.sv
// Three-byte packet framer: holds framing phase, header, X byte, buttons and deltas.
// Depends on ps2mct_pkg.
module ps2mct_framer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   enable,
	input  logic [7:0]             rx_byte,
	output ps2mct_pkg::pkt_info_t  info
);
	import ps2mct_pkg::*;

	frame_phase_t      phase_q, phase_d;
	logic [7:0]        header_q, header_d;
	logic [7:0]        x_byte_q, x_byte_d;
	logic [2:0]        buttons_q;
	logic signed [7:0] x_delta_q, y_delta_q;

	always_comb begin
		phase_d  = phase_q;
		header_d = header_q;
		x_byte_d = x_byte_q;
		info.buttons       = buttons_q;
		info.x_delta       = x_delta_q;
		info.y_delta       = y_delta_q;
		info.button_event  = 1'b0;
		info.packet_done   = 1'b0;
		info.overflow_drop = 1'b0;
		if (enable) begin
			case (phase_q)
				PH_HEADER: begin
					header_d = rx_byte;
					phase_d  = PH_X;
				end
				PH_X: begin
					x_byte_d = rx_byte;
					phase_d  = PH_Y;
				end
				default: begin
					phase_d          = PH_HEADER;
					info.packet_done = 1'b1;
					if (header_q[HDR_Y_OVF] || header_q[HDR_X_OVF]) begin
						// drop the packet, keep buttons and deltas
						info.overflow_drop = 1'b1;
					end else begin
						info.button_event = (header_q[2:0] != 3'd0) || (buttons_q != 3'd0);
						info.buttons      = header_q[2:0];
						info.x_delta      = x_byte_q;
						info.y_delta      = rx_byte;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			header_q  <= '0;
			x_byte_q  <= '0;
			buttons_q <= '0;
			x_delta_q <= '0;
			y_delta_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			header_q  <= header_d;
			x_byte_q  <= x_byte_d;
			buttons_q <= info.buttons;
			x_delta_q <= info.x_delta;
			y_delta_q <= info.y_delta;
		end
	end

endmodule

>>> rtl/core/ps2mct_motion.sv
// Motion tracker: scales deltas, accumulates them and steps the bounded cursor.
// Depends on ps2mct_pkg.
module ps2mct_motion (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic signed [7:0] x_delta,
	input  logic signed [7:0] y_delta,
	input  logic [6:0]        col_max,
	input  logic [4:0]        row_max,
	input  logic [5:0]        x_thr,
	input  logic [4:0]        y_thr,
	output logic [6:0]        col_next,
	output logic [4:0]        row_next
);
	import ps2mct_pkg::*;

	logic signed [6:0] x_accum_q, x_accum_d;
	logic signed [5:0] y_accum_q, y_accum_d;
	logic [6:0]        col_q;
	logic [4:0]        row_q;

	logic signed [7:0] cx, xq, x_sum, x_thr_s;
	logic signed [7:0] cy, yq;
	logic [6:0]        y_mag;
	logic [12:0]       y_prod;
	logic [3:0]        y_quot;
	logic signed [6:0] y_sum, y_thr_s;
	logic              x_up, x_dn, y_up, y_dn;
	logic signed [8:0] col_tmp;
	logic signed [6:0] row_tmp;

	always_comb begin
		// X: clamp to +-80, halve with truncation toward zero
		if (x_delta > X_CLAMP)
			cx = X_CLAMP;
		else if (x_delta < -X_CLAMP)
			cx = -X_CLAMP;
		else
			cx = x_delta;
		xq = (cx + $signed({7'b0, cx[7]})) >>> 1;

		// Y: clamp to +-64, divide magnitude by six through the reciprocal
		if (y_delta > Y_CLAMP)
			cy = Y_CLAMP;
		else if (y_delta < -Y_CLAMP)
			cy = -Y_CLAMP;
		else
			cy = y_delta;
		y_mag  = cy[7] ? 7'(-cy) : cy[6:0];
		y_prod = {6'b0, y_mag} * {7'b0, DIV6_RECIP};
		y_quot = y_prod[11:8];
		yq     = cy[7] ? -$signed({4'b0, y_quot}) : $signed({4'b0, y_quot});

		x_sum   = 8'(x_accum_q) + xq;
		x_thr_s = $signed({2'b0, x_thr});
		x_up    = x_sum > x_thr_s;
		x_dn    = x_sum < -x_thr_s;
		x_accum_d = (x_up || x_dn) ? 7'sd0 : x_sum[6:0];

		y_sum   = 7'(y_accum_q) + yq[6:0];
		y_thr_s = $signed({2'b0, y_thr});
		y_up    = y_sum > y_thr_s;
		y_dn    = y_sum < -y_thr_s;
		y_accum_d = (y_up || y_dn) ? 6'sd0 : y_sum[5:0];

		// X+ moves right; Y+ moves up, so the row decreases
		col_tmp = $signed({2'b0, col_q});
		if (x_up)
			col_tmp = col_tmp + 9'sd1;
		else if (x_dn)
			col_tmp = col_tmp - 9'sd1;
		if (col_tmp < 9'sd0)
			col_next = '0;
		else if (col_tmp > $signed({2'b0, col_max}))
			col_next = col_max;
		else
			col_next = col_tmp[6:0];

		row_tmp = $signed({2'b0, row_q});
		if (y_up)
			row_tmp = row_tmp - 7'sd1;
		else if (y_dn)
			row_tmp = row_tmp + 7'sd1;
		if (row_tmp < 7'sd0)
			row_next = '0;
		else if (row_tmp > $signed({2'b0, row_max}))
			row_next = row_max;
		else
			row_next = row_tmp[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_accum_q <= '0;
			y_accum_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (step) begin
			x_accum_q <= x_accum_d;
			y_accum_q <= y_accum_d;
			col_q     <= col_next;
			row_q     <= row_next;
		end
	end

endmodule

>>> rtl/core/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse packet framer and text-cursor tracker, top level.
// Throughput: one byte per cycle, set by the single update from the input
// register into the result register; result register stalls only on out_ready.
// Reset (arst_n low, asynchronous): framing, buttons, deltas, accumulators and
// cursor go to zero; configuration returns to disabled, 79 x 24, thresholds 6 and 8.
// Depends on ps2mct_pkg, ps2mct_framer and ps2mct_motion.
module ps2_mouse_packet_cursor_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port
	input  logic                                cfg_wr_en,
	input  logic [ps2mct_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ps2mct_pkg::CFG_DATA_W-1:0]   cfg_data,
	// Byte input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          rx_byte,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [6:0]                          cursor_col,
	output logic [4:0]                          cursor_row,
	output logic                                left_down,
	output logic                                right_down,
	output logic                                middle_down,
	output logic [1:0]                          glyph,
	output logic                                button_event,
	output logic                                packet_done,
	output logic                                overflow_drop
);
	import ps2mct_pkg::*;

	// Configuration registers
	logic       enable_q;
	logic [6:0] col_max_q;
	logic [4:0] row_max_q;
	logic [5:0] x_thr_q;
	logic [4:0] y_thr_q;

	// Input register
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// Result register
	logic       valid_s2;
	logic [6:0] col_s2;
	logic [4:0] row_s2;
	logic [2:0] buttons_s2;
	logic [1:0] glyph_s2;
	logic       event_s2, done_s2, drop_s2;

	logic       advance;
	pkt_info_t  info;
	logic [6:0] col_next;
	logic [4:0] row_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			col_max_q <= COL_MAX_RST;
			row_max_q <= ROW_MAX_RST;
			x_thr_q   <= X_THR_RST;
			y_thr_q   <= Y_THR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ENABLE:  enable_q  <= cfg_data[0];
				CFG_COL_MAX: col_max_q <= cfg_data[6:0];
				CFG_ROW_MAX: row_max_q <= cfg_data[4:0];
				CFG_X_THR:   x_thr_q   <= cfg_data[5:0];
				CFG_Y_THR:   y_thr_q   <= cfg_data[4:0];
				default:     ; // drop writes to unmapped indexes
			endcase
		end
	end

	// Advance the held byte whenever the result register is free or being drained;
	// the state update happens on this same edge.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	ps2mct_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.enable  (enable_q),
		.rx_byte (rx_byte_s1),
		.info    (info)
	);

	// Movement uses the deltas as they stand after this byte's framing
	ps2mct_motion u_motion (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.x_delta  (info.x_delta),
		.y_delta  (info.y_delta),
		.col_max  (col_max_q),
		.row_max  (row_max_q),
		.x_thr    (x_thr_q),
		.y_thr    (y_thr_q),
		.col_next (col_next),
		.row_next (row_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			col_s2     <= col_next;
			row_s2     <= row_next;
			buttons_s2 <= info.buttons;
			glyph_s2   <= glyph_of(info.buttons);
			event_s2   <= info.button_event;
			done_s2    <= info.packet_done;
			drop_s2    <= info.overflow_drop;
		end
	end

	assign out_valid     = valid_s2;
	assign cursor_col    = col_s2;
	assign cursor_row    = row_s2;
	assign left_down     = buttons_s2[BTN_LEFT];
	assign right_down    = buttons_s2[BTN_RIGHT];
	assign middle_down   = buttons_s2[BTN_MIDDLE];
	assign glyph         = glyph_s2;
	assign button_event  = event_s2;
	assign packet_done   = done_s2;
	assign overflow_drop = drop_s2;

endmodule
